/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/hcbd_pkg.sv */
`timescale 1ns / 1ps

package hcbd_pkg;

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_OK   = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      status_type  status;
      logic [31:0] decoded_count;
   } result_type;

endpackage

/* rtl/core/hcbd_stream_if.sv */
`timescale 1ns / 1ps

interface hcbd_stream_if #(
   parameter type PAYLOAD_TYPE = logic
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps
// an accepted item is first held in the input register, then its result is
//    registered in the parser result register, from which it can be taken
// throughput: one item per cycle while the result side takes results, set by the
//    parser state register that is updated once per item in a single pass
// reset (synchronous, active high) empties both stages and returns the parser
//    to the size line with zero count and status in progress
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   hcbd_stream_if.sink   req,
   hcbd_stream_if.source rsp
);
   import hcbd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       accept;
   result_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         item_ff <= req.payload;
      end
   end

   hcbd_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .item   (item_ff),
      .result (result)
   );

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = result;

endmodule

/* rtl/core/hcbd_parser.sv */
`timescale 1ns / 1ps

module hcbd_parser #(
   parameter int SIZE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  hcbd_pkg::item_type   item,
   output hcbd_pkg::result_type result
);
   import hcbd_pkg::*;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_EXT,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_DONE
   } phase_type;

   // bit 4 set when the byte is a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b1, b[3:0]};
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         v = {1'b1, b[3:0] + 4'd9};
      end
      return v;
   endfunction

   phase_type              phase_ff, phase_in, ph;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in, rem;
   logic                   seen_ff, seen_in, seen;
   logic [31:0]            total_ff, total_in, total;
   status_type             status_ff, status_in, st;
   result_type             result_ff, result_in;
   logic [4:0]             hv;
   logic                   pv;

   always_comb begin
      // a first byte starts from the reset state
      ph    = item.first_byte ? PH_SIZE : phase_ff;
      rem   = item.first_byte ? '0 : rem_ff;
      seen  = item.first_byte ? 1'b0 : seen_ff;
      total = item.first_byte ? 32'd0 : total_ff;
      st    = item.first_byte ? ST_BUSY : status_ff;

      phase_in  = ph;
      rem_in    = rem;
      seen_in   = seen;
      total_in  = total;
      status_in = st;
      pv        = 1'b0;
      hv        = hex_val(item.data_byte);

      if (st == ST_BUSY) begin
         unique case (ph)
            PH_SIZE: begin
               if (item.data_byte == CHAR_CR || item.data_byte == CHAR_SEMI) begin
                  if (!seen) begin
                     status_in = ST_BAD;
                     phase_in  = PH_DONE;
                  end else begin
                     phase_in = (item.data_byte == CHAR_CR) ? PH_SIZE_LF : PH_EXT;
                  end
               end else if (!hv[4] || rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                  status_in = ST_BAD;
                  phase_in  = PH_DONE;
               end else begin
                  rem_in  = {rem[SIZE_BITS-5:0], hv[3:0]};
                  seen_in = 1'b1;
               end
            end
            PH_EXT: begin
               if (item.data_byte == CHAR_CR) begin
                  phase_in = PH_SIZE_LF;
               end
            end
            PH_SIZE_LF: begin
               if (item.data_byte != CHAR_LF) begin
                  status_in = ST_BAD;
                  phase_in  = PH_DONE;
               end else if (rem == '0) begin
                  status_in = ST_OK;
                  phase_in  = PH_DONE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               pv       = 1'b1;
               total_in = total + 32'd1;
               rem_in   = rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};
               if (rem == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (item.data_byte == CHAR_CR) begin
                  phase_in = PH_DATA_LF;
               end else begin
                  status_in = ST_BAD;
                  phase_in  = PH_DONE;
               end
            end
            PH_DATA_LF: begin
               if (item.data_byte == CHAR_LF) begin
                  phase_in = PH_SIZE;
                  rem_in   = '0;
                  seen_in  = 1'b0;
               end else begin
                  status_in = ST_BAD;
                  phase_in  = PH_DONE;
               end
            end
            default: begin
               status_in = ST_BAD;
               phase_in  = PH_DONE;
            end
         endcase
         // early end of the response
         if (item.last_byte && status_in == ST_BUSY) begin
            status_in = ST_BAD;
            phase_in  = PH_DONE;
         end
      end

      result_in.payload_byte  = pv ? item.data_byte : 8'h00;
      result_in.payload_valid = pv;
      result_in.status        = status_in;
      result_in.decoded_count = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         rem_ff    <= '0;
         seen_ff   <= 1'b0;
         total_ff  <= 32'd0;
         status_ff <= ST_BUSY;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         seen_ff   <= seen_in;
         total_ff  <= total_in;
         status_ff <= status_in;
      end
      if (step_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* rtl/core/hcbd_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hcbd_pkg::result_type rsp_payload
);
   import hcbd_pkg::*;

   logic        have_ff;
   logic [31:0] last_cnt_ff;
   logic        take;
   logic        status_known;
   logic        count_next;

   assign take = rsp_valid && rsp_ready;

   assign status_known = rsp_payload.status == ST_BUSY || rsp_payload.status == ST_OK
                         || rsp_payload.status == ST_BAD;
   assign count_next   = rsp_payload.decoded_count == last_cnt_ff + 32'd1;

   // count of the last item delivered since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff     <= 1'b0;
         last_cnt_ff <= 32'd0;
      end else if (take) begin
         have_ff     <= 1'b1;
         last_cnt_ff <= rsp_payload.decoded_count;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `ASSERT_IMPLIES(a_status_code, rsp_valid, status_known)
   `ASSERT_IMPLIES(a_idle_byte_zero, rsp_valid && !rsp_payload.payload_valid, rsp_payload.payload_byte == 8'h00)
   `ASSERT_IMPLIES(a_count_step, take && have_ff && rsp_payload.payload_valid, count_next)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_payload(rsp.payload)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import hcbd_pkg::*;

   localparam int SIZE_BITS   = 32;
   localparam int ITEM_TARGET = 820;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 10;

   localparam logic [7:0] ASCII_ZERO  = "0";
   localparam logic [7:0] ASCII_UPPER = "A";
   localparam logic [7:0] ASCII_LOWER = "a";

   typedef enum logic [2:0] {
      PH_SIZE, PH_EXT, PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_DONE
   } parse_phase_type;

   // mirrors the decoder state and holds the results still owed by the block
   class chunk_scoreboard;
      parse_phase_type      phase = PH_SIZE;
      logic [SIZE_BITS-1:0] chunk_left = '0;
      bit                   digit_seen = 0;
      logic [31:0]          byte_total = '0;
      status_type           verdict = ST_BUSY;
      result_type           owed_q[$];
      int                   mismatches = 0;
      int                   checked = 0;
      int                   complete_count = 0;
      int                   malformed_count = 0;

      function void clear();
         phase = PH_SIZE;
         chunk_left = '0;
         digit_seen = 0;
         byte_total = '0;
         verdict = ST_BUSY;
      endfunction

      function void end_message(status_type st);
         verdict = st;
         phase = PH_DONE;
         if (st == ST_OK) complete_count++;
         else malformed_count++;
      endfunction

      function int hex_nibble_of(logic [7:0] b);
         if (b >= "0" && b <= "9") return int'(b) - int'("0");
         if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
         if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
         return -1;
      endfunction

      function void note_input(item_type it);
         logic [7:0] b;
         int         d;
         bit         pv;
         result_type want;
         b = it.data_byte;
         pv = 0;
         if (it.first_byte) clear();
         if (verdict == ST_BUSY) begin
            case (phase)
               PH_SIZE: begin
                  if (b == CHAR_CR || b == CHAR_SEMI) begin
                     if (!digit_seen) end_message(ST_BAD);
                     else phase = (b == CHAR_CR) ? PH_SIZE_LF : PH_EXT;
                  end else begin
                     d = hex_nibble_of(b);
                     // a set top nibble means one more digit would not fit
                     if (d < 0 || chunk_left[SIZE_BITS-1 -: 4] != 0) begin
                        end_message(ST_BAD);
                     end else begin
                        chunk_left = {chunk_left[SIZE_BITS-5:0], d[3:0]};
                        digit_seen = 1;
                     end
                  end
               end
               PH_EXT: begin
                  if (b == CHAR_CR) phase = PH_SIZE_LF;
               end
               PH_SIZE_LF: begin
                  if (b != CHAR_LF) end_message(ST_BAD);
                  else if (chunk_left == 0) end_message(ST_OK);
                  else phase = PH_DATA;
               end
               PH_DATA: begin
                  pv = 1;
                  byte_total += 1;
                  chunk_left -= 1;
                  if (chunk_left == 0) phase = PH_DATA_CR;
               end
               PH_DATA_CR: begin
                  if (b == CHAR_CR) phase = PH_DATA_LF;
                  else end_message(ST_BAD);
               end
               PH_DATA_LF: begin
                  if (b == CHAR_LF) begin
                     phase = PH_SIZE;
                     chunk_left = '0;
                     digit_seen = 0;
                  end else begin
                     end_message(ST_BAD);
                  end
               end
               default: end_message(ST_BAD);
            endcase
            if (it.last_byte && verdict == ST_BUSY) end_message(ST_BAD);
         end
         want.payload_byte  = pv ? b : 8'h00;
         want.payload_valid = pv;
         want.status        = verdict;
         want.decoded_count = byte_total;
         owed_q.push_back(want);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result: byte %h valid %b status %0d count %0d",
                     $time, got.payload_byte, got.payload_valid, got.status,
                     got.decoded_count);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (got !== want) begin
            $display("%0t: mismatch: expected byte %h valid %b status %0d count %0d",
                     $time, want.payload_byte, want.payload_valid, want.status,
                     want.decoded_count);
            $display("%0t:           actual   byte %h valid %b status %0d count %0d",
                     $time, got.payload_byte, got.payload_valid, got.status,
                     got.decoded_count);
            mismatches++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   hcbd_stream_if #(.PAYLOAD_TYPE(item_type))   req_if ();
   hcbd_stream_if #(.PAYLOAD_TYPE(result_type)) rsp_if ();

   http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   chunk_scoreboard sb;
   logic [7:0]      body_q[$];
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              good_msgs = 0;
   int              broken_msgs = 0;
   int              noise_bursts = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: check whatever is taken, then pick ready for the next cycle
   always @(posedge clock) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) sb.check_result(rsp_if.payload);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sb.note_input(it);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_body(bit mark_last, int last_at);
      item_type it;
      for (int i = 0; i < body_q.size(); i++) begin
         it.data_byte  = body_q[i];
         it.first_byte = (i == 0);
         it.last_byte  = mark_last && (i == last_at);
         send_item(it);
      end
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endtask

   task automatic push_digit(logic [3:0] v);
      if (v < 10) body_q.push_back(8'(ASCII_ZERO + v));
      else if ($urandom_range(1)) body_q.push_back(8'(ASCII_UPPER + v - 10));
      else body_q.push_back(8'(ASCII_LOWER + v - 10));
   endtask

   task automatic push_hex(logic [31:0] value, int pad);
      int n;
      n = 1;
      while (n < 8 && (value >> (4 * n)) != 0) n++;
      repeat (pad) push_digit(4'h0);
      for (int i = n - 1; i >= 0; i--) push_digit(value[4*i +: 4]);
   endtask

   task automatic push_size_line(logic [31:0] value);
      logic [7:0] b;
      push_hex(value, $urandom_range(2));
      if ($urandom_range(3) == 0) begin
         body_q.push_back(CHAR_SEMI);
         repeat ($urandom_range(6)) begin
            b = 8'($urandom_range(255));
            body_q.push_back((b == CHAR_CR) ? 8'h20 : b);
         end
      end
      body_q.push_back(CHAR_CR);
      body_q.push_back(CHAR_LF);
   endtask

   task automatic build_good_message(output int done_at);
      int r;
      int size;
      body_q.delete();
      repeat ($urandom_range(1, 4)) begin
         r = $urandom_range(9);
         if (r < 7) size = $urandom_range(1, 8);
         else if (r < 9) size = $urandom_range(9, 40);
         else size = $urandom_range(41, 120);
         push_size_line(size);
         repeat (size) body_q.push_back(8'($urandom_range(255)));
         body_q.push_back(CHAR_CR);
         body_q.push_back(CHAR_LF);
      end
      push_size_line(0);
      done_at = body_q.size() - 1;
      // trailer bytes after completion are ignored
      repeat ($urandom_range(4)) body_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_good_message();
      int done_at;
      build_good_message(done_at);
      send_body($urandom_range(3) != 0, body_q.size() - 1);
      good_msgs++;
   endtask

   task automatic send_broken_message();
      int done_at;
      int k;
      build_good_message(done_at);
      case ($urandom_range(3))
         0: begin
            body_q[$urandom_range(done_at)] = 8'($urandom_range(255));
            send_body(1'b1, body_q.size() - 1);
         end
         1: begin
            // cut short with the end mark before completion
            k = $urandom_range(done_at - 1);
            while (body_q.size() > k + 1) void'(body_q.pop_back());
            send_body(1'b1, k);
         end
         2: begin
            // eight digits with the top nibble set: one more overflows
            body_q.delete();
            push_digit(4'($urandom_range(1, 15)));
            repeat (7) push_digit(4'($urandom_range(15)));
            if ($urandom_range(1)) begin
               push_digit(4'($urandom_range(15)));
            end else begin
               push_text("\r\n");
               repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(255)));
            end
            send_body(1'b1, body_q.size() - 1);
         end
         default: begin
            body_q.delete($urandom_range(done_at));
            send_body($urandom_range(1), body_q.size() - 1);
         end
      endcase
      broken_msgs++;
   endtask

   task automatic send_noise();
      item_type it;
      repeat ($urandom_range(1, 10)) begin
         it.data_byte  = 8'($urandom_range(255));
         it.first_byte = ($urandom_range(3) == 0);
         it.last_byte  = ($urandom_range(7) == 0);
         send_item(it);
      end
      noise_bursts++;
   endtask

   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      int base;
      int r;
      idle_by_phase  = '{0, 83, 0, 11};
      stall_by_phase = '{0, 0, 83, 11};
      sb = new;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: a complete message with extension and extreme data bytes
      body_q.delete();
      push_text("2;\r\n");
      body_q.push_back(8'hFF);
      body_q.push_back(8'h00);
      push_text("\r\n0\r\n");
      send_body(1'b1, body_q.size() - 1);
      // empty size
      body_q.delete();
      push_text("\r");
      send_body(1'b0, 0);
      // missing line feed after the size line
      body_q.delete();
      push_text("1\rX");
      send_body(1'b0, 0);
      // bad size character, also the end mark
      body_q.delete();
      push_text("g");
      send_body(1'b1, 0);
      // size overflow
      body_q.delete();
      push_text("Fffffffff");
      send_body(1'b0, 0);
      // early end on a size digit
      body_q.delete();
      push_text("1");
      send_body(1'b1, 0);

      base = items_sent;
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         idle_pct  = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         while (items_sent < base + ITEM_TARGET * (p + 1) / 4) begin
            r = $urandom_range(99);
            if (r < 65) send_good_message();
            else if (r < 90) send_broken_message();
            else send_noise();
         end
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d bytes: %0d sound messages, %0d damaged, %0d noise bursts",
               items_sent, good_msgs, broken_msgs, noise_bursts);
      $display("%0d results checked, %0d messages complete, %0d malformed",
               sb.checked, sb.complete_count, sb.malformed_count);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
